>>> sv/byte_rate_pressure_meter_macros.svh
// assertion helpers shared by the rate meter modules
// both expect i_clk and i_rst_n in the module that uses them
`ifndef BYTE_RATE_PRESSURE_METER_MACROS_SVH
`define BYTE_RATE_PRESSURE_METER_MACROS_SVH

// condition implies expression in the same cycle
`define BRPM_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("brpm assertion failed");

// condition implies expression in the next cycle
`define BRPM_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("brpm assertion failed");

`endif

>>> sv/brpm_pkg.sv
`default_nettype none
package brpm_pkg;

    localparam int DATA_W    = 64;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int LVL_W     = 2;
    localparam int NUM_W     = 84;
    localparam int ALU_W     = 85;
    localparam int STEP_W    = 7;
    localparam int MUL_STEPS = 20;
    localparam int DIV_STEPS = NUM_W;
    localparam int MUL_IDX_W = $clog2(MUL_STEPS);

    localparam logic [MUL_STEPS-1:0] US_PER_SEC     = 20'd1000000;
    localparam logic [DATA_W-1:0]    MIN_ELAPSED_US = 64'd1000000;

    localparam logic [CFG_W-1:0] HIGH_THR_RST = 32'd67108864;
    localparam logic [CFG_W-1:0] ELEV_THR_RST = 32'd16777216;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_THR = 2'd1;

    localparam logic [LVL_W-1:0] LVL_NONE     = 2'd0;
    localparam logic [LVL_W-1:0] LVL_ACTIVE   = 2'd1;
    localparam logic [LVL_W-1:0] LVL_ELEVATED = 2'd2;
    localparam logic [LVL_W-1:0] LVL_HIGH     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_DELTA,
        S_MUL,
        S_DIV,
        S_LEVEL,
        S_OUT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic in_ready;
        logic do_diff;
        logic do_delta;
        logic do_mul;
        logic mul_bit;
        logic do_div;
        logic do_level;
        logic do_out;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic have_base;
        logic elapsed_ok;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

>>> sv/brpm_alu.sv
`default_nettype none
module brpm_alu (
    input  brpm_pkg::t_alu_op              i_op,
    input  logic [brpm_pkg::ALU_W-1:0]     i_a,
    input  logic [brpm_pkg::ALU_W-1:0]     i_b,
    output logic [brpm_pkg::ALU_W-1:0]     o_y,
    output logic                           o_borrow
);
    import brpm_pkg::*;

    logic [ALU_W:0] ext;

    always_comb begin
        case (i_op)
            ALU_ADD: ext = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: ext = {1'b0, i_a} - {1'b0, i_b};
            default: ext = '0;
        endcase
    end

    assign o_y      = ext[ALU_W-1:0];
    // only meaningful for a subtract
    assign o_borrow = (i_op == ALU_SUB) && ext[ALU_W];

endmodule
`default_nettype wire

>>> sv/brpm_ctrl.sv
`default_nettype none
module brpm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brpm_pkg::t_stat i_stat,
    output brpm_pkg::t_ctrl o_ctrl
);
    import brpm_pkg::*;

    `include "byte_rate_pressure_meter_macros.svh"

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_fire) begin
                    n_state = i_stat.have_base ? S_DIFF : S_OUT;
                end
            end
            S_DIFF: begin
                n_state = i_stat.elapsed_ok ? S_DELTA : S_OUT;
            end
            S_DELTA: begin
                n_state = S_MUL;
                n_step  = STEP_W'(MUL_STEPS - 1);
            end
            S_MUL: begin
                if (r_step == '0) begin
                    n_state = S_DIV;
                    n_step  = STEP_W'(DIV_STEPS - 1);
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_LEVEL;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_LEVEL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl = '0;
        case (r_state)
            S_IDLE:  o_ctrl.in_ready = 1'b1;
            S_DIFF:  o_ctrl.do_diff  = 1'b1;
            S_DELTA: o_ctrl.do_delta = 1'b1;
            S_MUL: begin
                o_ctrl.do_mul  = 1'b1;
                // multiplier bits of one million, msb first
                o_ctrl.mul_bit = US_PER_SEC[r_step[MUL_IDX_W-1:0]];
            end
            S_DIV:   o_ctrl.do_div   = 1'b1;
            S_LEVEL: o_ctrl.do_level = 1'b1;
            S_OUT:   o_ctrl.do_out   = 1'b1;
            default: o_ctrl = '0;
        endcase
    end

    `BRPM_ASSERT_NOW(a_mul_step_range, r_state == S_MUL, r_step < STEP_W'(MUL_STEPS))
    `BRPM_ASSERT_NEXT(a_div_to_level, (r_state == S_DIV) && (r_step == '0), r_state == S_LEVEL)
    `BRPM_ASSERT_NEXT(a_out_to_idle, (r_state == S_OUT) && i_stat.out_free, r_state == S_IDLE)

endmodule
`default_nettype wire

>>> sv/byte_rate_pressure_meter.sv
// byte rate pressure meter
// input channel (i_in_valid / o_in_ready) takes one sample: byte counter and
// microsecond timestamp. output channel (o_out_valid / i_out_ready) returns
// one item per sample: floored bytes per second and a two-bit level.
// thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// writes them only while idle, the block itself does not enforce it.
// the first sample after reset only sets the baseline. a sample less than
// one second past the baseline returns the held values. a recompute runs a
// shared 85-bit add/subtract unit: 20 shift-add steps form count delta times
// one million, then 84 restoring divide steps by the elapsed time. one sample
// is in flight at a time; o_in_ready returns in the cycle the result is shown.
// the result sits in an output register; if the receiver stalls, a finished
// sample waits in its last step until that register is free.
// reset clears the baseline, held rate and level, and loads the default
// thresholds.
`default_nettype none
module byte_rate_pressure_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic        [brpm_pkg::DATA_W-1:0]  i_byte_count,
    input  logic signed [brpm_pkg::DATA_W-1:0]  i_time_us,
    input  logic                                i_cfg_we,
    input  logic        [brpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [brpm_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic        [brpm_pkg::DATA_W-1:0]  o_rate,
    output logic        [brpm_pkg::LVL_W-1:0]   o_level
);
    import brpm_pkg::*;

    `include "byte_rate_pressure_meter_macros.svh"

    t_ctrl ctrl;
    t_stat stat;

    logic [CFG_W-1:0]  r_high_thr;
    logic [CFG_W-1:0]  r_elev_thr;
    logic              r_have_base;
    logic [DATA_W-1:0] r_base_cnt;
    logic [DATA_W-1:0] r_base_time;
    logic [DATA_W-1:0] r_held_rate;
    logic [LVL_W-1:0]  r_held_level;
    logic              r_out_valid;

    logic [DATA_W-1:0] r_cnt;
    logic [DATA_W-1:0] r_now;
    logic [DATA_W-1:0] r_diff;
    logic [DATA_W-1:0] r_d;
    logic              r_dnz;
    logic [NUM_W-1:0]  r_acc;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_out_rate;
    logic [LVL_W-1:0]  r_out_level;

    t_alu_op           alu_op;
    logic [ALU_W-1:0]  alu_a;
    logic [ALU_W-1:0]  alu_b;
    logic [ALU_W-1:0]  alu_y;
    logic              alu_borrow;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W-1:0] quo;
    logic [LVL_W-1:0]  lvl;
    logic              in_fire;
    logic              out_free;

    brpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    brpm_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    assign o_in_ready = ctrl.in_ready;
    assign in_fire    = i_in_valid && ctrl.in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // next dividend bit shifts from the top of the accumulator into the remainder
    assign rem_sh = {r_rem, r_acc[NUM_W-1]};
    assign quo    = r_acc[DATA_W-1:0];

    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        if (ctrl.do_diff) begin
            alu_op = ALU_SUB;
            alu_a  = {{(ALU_W-DATA_W){1'b0}}, r_now};
            alu_b  = {{(ALU_W-DATA_W){1'b0}}, r_base_time};
        end else if (ctrl.do_delta) begin
            alu_op = ALU_SUB;
            alu_a  = {{(ALU_W-DATA_W){1'b0}}, r_cnt};
            alu_b  = {{(ALU_W-DATA_W){1'b0}}, r_base_cnt};
        end else if (ctrl.do_mul) begin
            alu_a  = {1'b0, r_acc[NUM_W-2:0], 1'b0};
            alu_b  = ctrl.mul_bit ? {{(ALU_W-DATA_W){1'b0}}, r_d} : '0;
        end else if (ctrl.do_div) begin
            alu_op = ALU_SUB;
            alu_a  = {{(ALU_W-DATA_W-1){1'b0}}, rem_sh};
            alu_b  = {{(ALU_W-DATA_W){1'b0}}, r_diff};
        end
    end

    always_comb begin
        stat.in_fire    = in_fire;
        stat.have_base  = r_have_base;
        // wrapped or negative elapsed time counts as too soon
        stat.elapsed_ok = ctrl.do_diff && !alu_y[DATA_W-1]
                          && (alu_y[DATA_W-1:0] >= MIN_ELAPSED_US);
        stat.out_free   = out_free;
    end

    always_comb begin
        if (quo >= {{(DATA_W-CFG_W){1'b0}}, r_high_thr}) begin
            lvl = LVL_HIGH;
        end else if (quo >= {{(DATA_W-CFG_W){1'b0}}, r_elev_thr}) begin
            lvl = LVL_ELEVATED;
        end else if (r_dnz) begin
            lvl = LVL_ACTIVE;
        end else begin
            lvl = LVL_NONE;
        end
    end

    // control and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr   <= HIGH_THR_RST;
            r_elev_thr   <= ELEV_THR_RST;
            r_have_base  <= 1'b0;
            r_base_cnt   <= '0;
            r_base_time  <= '0;
            r_held_rate  <= '0;
            r_held_level <= LVL_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HIGH_THR: r_high_thr <= i_cfg_data;
                    REG_ELEV_THR: r_elev_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire && !r_have_base) begin
                r_have_base  <= 1'b1;
                r_base_cnt   <= i_byte_count;
                r_base_time  <= i_time_us;
                r_held_rate  <= '0;
                r_held_level <= LVL_NONE;
            end
            if (ctrl.do_delta) begin
                r_base_cnt  <= r_cnt;
                r_base_time <= r_now;
            end
            if (ctrl.do_level) begin
                r_held_rate  <= quo;
                r_held_level <= lvl;
            end
            if (ctrl.do_out && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cnt <= i_byte_count;
            r_now <= i_time_us;
        end
        if (ctrl.do_diff) begin
            r_diff <= alu_y[DATA_W-1:0];
        end
        if (ctrl.do_delta) begin
            // counter went backwards: no bytes
            r_d   <= alu_borrow ? '0 : alu_y[DATA_W-1:0];
            r_dnz <= !alu_borrow && (alu_y[DATA_W-1:0] != '0);
            r_acc <= '0;
            r_rem <= '0;
        end
        if (ctrl.do_mul) begin
            r_acc <= alu_y[NUM_W-1:0];
        end
        if (ctrl.do_div) begin
            r_rem <= alu_borrow ? rem_sh[DATA_W-1:0] : alu_y[DATA_W-1:0];
            r_acc <= {r_acc[NUM_W-2:0], !alu_borrow};
        end
        if (ctrl.do_out && out_free) begin
            r_out_rate  <= r_held_rate;
            r_out_level <= r_held_level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rate      = r_out_rate;
    assign o_level     = r_out_level;

    `BRPM_ASSERT_NEXT(a_busy_after_accept, in_fire, !o_in_ready)
    `BRPM_ASSERT_NOW(a_rem_below_divisor, ctrl.do_div, r_rem < r_diff)
    `BRPM_ASSERT_NOW(a_quotient_fits, ctrl.do_level, r_acc[NUM_W-1:DATA_W] == '0)

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brpm_pkg::*;

    localparam logic [DATA_W-1:0] SEC_US     = 64'd1000000;
    localparam logic [DATA_W-1:0] ALL_ONES   = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] MAX_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_NEG    = 64'h8000_0000_0000_0000;
    localparam logic [CFG_W-1:0]  THR_MAX    = {CFG_W{1'b1}};
    localparam int                CYCLE_LIMIT = 2000000;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] rate;
        logic [LVL_W-1:0]  level;
    } t_meter_result;

    logic                        i_clk;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_ready;
    logic        [DATA_W-1:0]    i_byte_count = '0;
    logic signed [DATA_W-1:0]    i_time_us    = '0;
    logic                        i_cfg_we     = 1'b0;
    logic        [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic        [CFG_W-1:0]     i_cfg_data   = '0;
    logic                        o_out_valid;
    logic                        i_out_ready  = 1'b0;
    logic        [DATA_W-1:0]    o_rate;
    logic        [LVL_W-1:0]     o_level;

    // predictor state, mirrors the meter
    logic              base_valid;
    logic [DATA_W-1:0] base_cnt;
    logic [DATA_W-1:0] base_t;
    logic [DATA_W-1:0] held_rate;
    logic [LVL_W-1:0]  held_lvl;
    logic [CFG_W-1:0]  thr_high;
    logic [CFG_W-1:0]  thr_elev;

    t_meter_result     pending_rates[$];
    int                err_count    = 0;
    int                cycle_count  = 0;
    int                tx_idle_pct  = 0;
    int                rx_stall_pct = 0;
    int                hold_request = 0;
    int                hold_left    = 0;
    logic [DATA_W-1:0] sent_cnt     = '0;
    logic [DATA_W-1:0] sent_t       = '0;

    byte_rate_pressure_meter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_count (i_byte_count),
        .i_time_us    (i_time_us),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_rate       (o_rate),
        .o_level      (o_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic predict_rate(input logic [DATA_W-1:0] cnt, input logic [DATA_W-1:0] t,
                                output t_meter_result res);
        logic [DATA_W-1:0] elapsed;
        logic [DATA_W-1:0] delta;
        logic [127:0]      scaled;
        res.rate  = '0;
        res.level = LVL_NONE;
        if (!base_valid) begin
            base_valid = 1'b1;
            base_cnt   = cnt;
            base_t     = t;
            held_rate  = '0;
            held_lvl   = LVL_NONE;
        end else begin
            elapsed = t - base_t;
            if (!elapsed[DATA_W-1] && elapsed >= MIN_ELAPSED_US) begin
                delta    = (cnt >= base_cnt) ? cnt - base_cnt : '0;
                scaled   = {64'd0, delta} * {108'd0, US_PER_SEC};
                scaled   = scaled / {64'd0, elapsed};
                res.rate = scaled[DATA_W-1:0];
                if (res.rate >= {32'd0, thr_high})
                    res.level = LVL_HIGH;
                else if (res.rate >= {32'd0, thr_elev})
                    res.level = LVL_ELEVATED;
                else if (delta != 0)
                    res.level = LVL_ACTIVE;
                else
                    res.level = LVL_NONE;
                base_cnt  = cnt;
                base_t    = t;
                held_rate = res.rate;
                held_lvl  = res.level;
            end else begin
                res.rate  = held_rate;
                res.level = held_lvl;
            end
        end
    endtask

    // checks results, tracks config writes, predicts accepted items
    always @(posedge i_clk) begin
        t_meter_result want;
        t_meter_result got;
        if (!i_rst_n) begin
            base_valid = 1'b0;
            base_cnt   = '0;
            base_t     = '0;
            held_rate  = '0;
            held_lvl   = LVL_NONE;
            thr_high   = HIGH_THR_RST;
            thr_elev   = ELEV_THR_RST;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_rates.size() == 0) begin
                    $error("unexpected result: rate %0d level %0d", o_rate, o_level);
                    err_count++;
                end else begin
                    want = pending_rates.pop_front();
                    if (o_rate !== want.rate) begin
                        $error("rate mismatch: expected %0d, got %0d", want.rate, o_rate);
                        err_count++;
                    end
                    if (o_level !== want.level) begin
                        $error("level mismatch: expected %0d, got %0d", want.level, o_level);
                        err_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HIGH_THR: thr_high = i_cfg_data;
                    REG_ELEV_THR: thr_elev = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                predict_rate(i_byte_count, i_time_us, got);
                pending_rates.push_back(got);
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_stall_pct == 0) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic offer_sample(input logic [DATA_W-1:0] cnt, input logic [DATA_W-1:0] t);
        int gap;
        gap = 0;
        if (tx_idle_pct != 0) begin
            while ($urandom_range(0, 99) < tx_idle_pct)
                gap++;
            if ($urandom_range(0, 31) == 0)
                gap += $urandom_range(1, 130);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_byte_count <= cnt;
        i_time_us    <= t;
        i_in_valid   <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sent_cnt = cnt;
        sent_t   = t;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rates.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // reset thresholds, baseline, hold, every level, backwards counter, time wrap
    task automatic test_baseline_and_levels();
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] w;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        offer_sample(64'd100, 64'd0);
        offer_sample(64'd200, SEC_US - 1);
        c = 64'd100 + (64'd1 << 26);
        offer_sample(c, SEC_US);
        c = c + (64'd1 << 24);
        offer_sample(c, 2 * SEC_US);
        c = c + (64'd1 << 24) - 1;
        offer_sample(c, 3 * SEC_US);
        offer_sample(c, 4 * SEC_US);
        c = c - 50;
        offer_sample(c, 5 * SEC_US);
        // nonzero delta that floors to rate 0
        offer_sample(c + 1, 8 * SEC_US);
        offer_sample(c + 5, 7 * SEC_US);
        offer_sample(c + 5, 8 * SEC_US);
        offer_sample(64'd0, 9 * SEC_US);
        w = 64'h7FFF_FFFF_FFF0_0000;
        offer_sample(64'd10, w);
        // timestamp crosses into negative values, elapsed still positive
        offer_sample(ALL_ONES, w + 3 * SEC_US);
        offer_sample(64'd0, w + 4 * SEC_US);
        w = w + 4 * SEC_US + MAX_POS;
        offer_sample(ALL_ONES, w);
        offer_sample(64'd5, w + MIN_NEG);
        offer_sample(64'd0, w + SEC_US);
        offer_sample(ALL_ONES, w + 2 * SEC_US);
        offer_sample(64'd7, MIN_NEG);
        offer_sample(64'd9, MAX_POS);
        wait_results_drained();
    endtask

    task automatic test_threshold_extremes();
        tx_idle_pct  = 7;
        rx_stall_pct = 7;
        wait_results_drained();
        write_threshold(REG_HIGH_THR, '0);
        write_threshold(REG_ELEV_THR, '0);
        offer_sample(sent_cnt, sent_t + SEC_US);
        wait_results_drained();
        write_threshold(REG_HIGH_THR, THR_MAX);
        offer_sample(sent_cnt + 5, sent_t + SEC_US);
        wait_results_drained();
        write_threshold(REG_ELEV_THR, THR_MAX);
        offer_sample(sent_cnt + {32'd0, THR_MAX}, sent_t + SEC_US);
        offer_sample(sent_cnt + {32'd0, THR_MAX} - 1, sent_t + SEC_US);
        wait_results_drained();
        // unused register indexes leave the thresholds alone
        write_threshold(REG_SPARE_LO, '0);
        write_threshold(REG_SPARE_HI, '0);
        offer_sample(sent_cnt + {32'd0, THR_MAX} - 1, sent_t + SEC_US);
        offer_sample(sent_cnt + {32'd0, THR_MAX}, sent_t + SEC_US);
        wait_results_drained();
        write_threshold(REG_HIGH_THR, HIGH_THR_RST);
        write_threshold(REG_ELEV_THR, ELEV_THR_RST);
    endtask

    // receiver holds off long enough for the meter to refuse new items
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        wait_results_drained();
        hold_request = 600;
        repeat (8)
            offer_sample(sent_cnt + 64'($urandom >> $urandom_range(0, 31)),
                         sent_t + SEC_US + 64'($urandom_range(0, 1000000)));
        // sender pauses until every result is back
        wait_results_drained();
        repeat (4)
            offer_sample(sent_cnt + 64'($urandom >> 6),
                         sent_t + SEC_US + 64'($urandom_range(0, 9)));
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int                tx_pct[4];
        int                rx_pct[4];
        int                kind;
        logic [DATA_W-1:0] cnt;
        logic [DATA_W-1:0] t;
        tx_pct = '{0, 58, 0, 7};
        rx_pct = '{0, 0, 58, 7};
        for (int ph = 0; ph < 4; ph++) begin
            wait_results_drained();
            write_threshold(REG_HIGH_THR, $urandom >> $urandom_range(0, 31));
            write_threshold(REG_ELEV_THR, $urandom >> $urandom_range(0, 31));
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            for (int n = 0; n < 125; n++) begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    cnt = sent_cnt + (rand64() >> $urandom_range(0, 63));
                    t   = sent_t + 64'($urandom_range(1000000, 3000000));
                    if ($urandom_range(0, 15) == 0)
                        t = t + {24'd0, 8'($urandom_range(0, 255)), $urandom};
                end else if (kind < 82) begin
                    cnt = sent_cnt + 64'($urandom_range(0, 1 << 20));
                    t   = sent_t + 64'($urandom_range(0, 999999));
                end else if (kind < 90) begin
                    cnt = sent_cnt - (rand64() >> $urandom_range(1, 63));
                    t   = sent_t + 64'($urandom_range(1000000, 2000000));
                end else begin
                    cnt = rand64();
                    t   = rand64();
                end
                offer_sample(cnt, t);
            end
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_baseline_and_levels();
        test_threshold_extremes();
        test_output_backpressure();
        test_random_traffic();
        wait_results_drained();
        repeat (120) @(posedge i_clk);
        if (pending_rates.size() != 0) begin
            $error("%0d expected results never arrived", pending_rates.size());
            err_count++;
        end
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
